/* rtl/core/rotation_matrix_to_quaternion_defines.svh */
// Assertion macros used by the RTL of the quaternion converter.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rmq assertion failed");
`define RMQ_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rmq implication failed");
`else
`define RMQ_ASSERT(label, clk, rst_n, prop)
`define RMQ_ASSERT_IMPLY(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/core/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

    // Fixed-point format of every element.
    localparam int FRAC_BITS  = 14;
    localparam int ELEM_W     = 16;
    // Candidate sums and off-diagonal sums.
    localparam int M_W        = ELEM_W + 2;
    localparam int D_W        = ELEM_W + 1;
    // Square root: radicand is best << FRAC_BITS.
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int SQ_ITERS   = ROOT_W;
    localparam int SQ_PER_STG = 2;
    localparam int SQ_STAGES  = (SQ_ITERS + SQ_PER_STG - 1) / SQ_PER_STG;
    // Division: numerator (|d| << FRAC_BITS) + s over divisor 2s.
    localparam int NUM_W      = D_W + FRAC_BITS + 1;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int QUO_W      = NUM_W - (DIV_W - 2);
    localparam int DV_ITERS   = QUO_W;
    localparam int DV_PER_STG = 2;
    localparam int DV_STAGES  = (DV_ITERS + DV_PER_STG - 1) / DV_PER_STG;
    localparam int Q_W        = QUO_W + 1;
    // Cycles from accepted beat to result strobe.
    localparam int LATENCY    = SQ_STAGES + DV_STAGES + 3;

    typedef enum logic [1:0] {
        COMP_W,
        COMP_X,
        COMP_Y,
        COMP_Z
    } comp_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a00;
        logic signed [ELEM_W-1:0] a01;
        logic signed [ELEM_W-1:0] a02;
        logic signed [ELEM_W-1:0] a10;
        logic signed [ELEM_W-1:0] a11;
        logic signed [ELEM_W-1:0] a12;
        logic signed [ELEM_W-1:0] a20;
        logic signed [ELEM_W-1:0] a21;
        logic signed [ELEM_W-1:0] a22;
    } matrix_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_w;
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
    } quat_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [RAD_W-1:0]    rad;
    } sq_t;

    typedef struct packed {
        comp_t                idx;
        logic [2:0]           neg;
        logic [2:0][D_W-1:0]  dmag;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [NUM_W-1:0] num;
    } dv_t;

    typedef struct packed {
        comp_t             idx;
        logic [2:0]        neg;
        logic [ROOT_W-1:0] dom;
        logic [DIV_W-1:0]  divisor;
    } dside_t;

    // One iteration of the digit-by-digit integer square root.
    function automatic sq_t sq_step(input sq_t x);
        logic [SQ_REM_W-1:0] r;
        logic [SQ_REM_W-1:0] t;
        sq_t                 y;
        r = {x.rem[SQ_REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        t = {{(SQ_REM_W-ROOT_W-2){1'b0}}, x.root, 2'b01};
        y.rad = x.rad << 2;
        if (r >= t)
        begin
            y.rem  = r - t;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            y.rem  = r;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // One iteration of restoring division.
    function automatic dv_t dv_step(input dv_t x, input logic [DIV_W-1:0] d);
        logic [DIV_W:0] r;
        logic [DIV_W:0] diff;
        dv_t            y;
        r    = {x.rem, x.num[NUM_W-1]};
        diff = r - {1'b0, d};
        y.num = x.num << 1;
        if (r >= {1'b0, d})
        begin
            y.rem = diff[DIV_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = r[DIV_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion converter (Shepperd's method), Q2.14.
// Input channel: drive the nine matrix elements on matrix and raise start;
// the beat is taken at the rising edge where start is high and busy is low.
// busy is always low, so a new matrix can be taken on every cycle.
// Output channel: done is high for exactly one cycle with the quaternion
// on quat; the receiver must take it in that cycle.
// The pipeline runs candidate selection, then the square root (two root
// bits per stage), then forming the dividends, then the three parallel
// dividers (two quotient bits per stage, one in the last), and last the
// sign fix and saturation. Throughput is one matrix per cycle, set by the
// fully pipelined square root and divider units.
// Reset clears all stage valid bits, so no result appears until a beat has
// gone through the whole pipeline. Results leave in the order of arrival.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rmq_pkg::matrix_t matrix,
    output logic                 done,
    output rmq_pkg::quat_t       quat
);

    localparam int SQS = rmq_pkg::SQ_STAGES;
    localparam int DVS = rmq_pkg::DV_STAGES;
    localparam int MW  = rmq_pkg::M_W;
    localparam int DW  = rmq_pkg::D_W;
    localparam int QW  = rmq_pkg::Q_W;
    localparam int RW  = rmq_pkg::ROOT_W;

    assign busy = 1'b0;

    // Stage A: candidate sums, largest pick and off-diagonal terms.
    logic signed [MW-1:0] m0, m1, m2, m3, one_m, best;
    logic signed [MW-1:0] e00, e11, e22;
    rmq_pkg::comp_t       idx_sel;
    logic signed [DW-1:0] dx, dy, dz, sxy, sxz, syz;
    logic signed [DW-1:0] d0, d1, d2;
    rmq_pkg::side_t       side_a_next;
    rmq_pkg::sq_t         sq_a_next;
    logic                 a_v_reg;
    rmq_pkg::side_t       side_a_reg;
    rmq_pkg::sq_t         sq_a_reg;

    always_comb
    begin
        one_m = MW'(1 << rmq_pkg::FRAC_BITS);
        e00   = MW'(matrix.a00);
        e11   = MW'(matrix.a11);
        e22   = MW'(matrix.a22);
        m0 = one_m + e00 + e11 + e22;
        m1 = one_m + e00 - e11 - e22;
        m2 = one_m - e00 + e11 - e22;
        m3 = one_m - e00 - e11 + e22;
        best    = m0;
        idx_sel = rmq_pkg::COMP_W;
        if (m1 > best)
        begin
            best    = m1;
            idx_sel = rmq_pkg::COMP_X;
        end
        if (m2 > best)
        begin
            best    = m2;
            idx_sel = rmq_pkg::COMP_Y;
        end
        if (m3 > best)
        begin
            best    = m3;
            idx_sel = rmq_pkg::COMP_Z;
        end
        if (best < one_m)
        begin
            best = one_m;
        end
        dx  = DW'(matrix.a12) - DW'(matrix.a21);
        dy  = DW'(matrix.a20) - DW'(matrix.a02);
        dz  = DW'(matrix.a01) - DW'(matrix.a10);
        sxy = DW'(matrix.a01) + DW'(matrix.a10);
        sxz = DW'(matrix.a02) + DW'(matrix.a20);
        syz = DW'(matrix.a12) + DW'(matrix.a21);
        unique case (idx_sel)
            rmq_pkg::COMP_W:
            begin
                d0 = dx;
                d1 = dy;
                d2 = dz;
            end
            rmq_pkg::COMP_X:
            begin
                d0 = dx;
                d1 = sxy;
                d2 = sxz;
            end
            rmq_pkg::COMP_Y:
            begin
                d0 = dy;
                d1 = sxy;
                d2 = syz;
            end
            default:
            begin
                d0 = dz;
                d1 = sxz;
                d2 = syz;
            end
        endcase
        side_a_next.idx     = idx_sel;
        side_a_next.neg     = {d2[DW-1], d1[DW-1], d0[DW-1]};
        side_a_next.dmag[0] = d0[DW-1] ? DW'(-d0) : DW'(d0);
        side_a_next.dmag[1] = d1[DW-1] ? DW'(-d1) : DW'(d1);
        side_a_next.dmag[2] = d2[DW-1] ? DW'(-d2) : DW'(d2);
        sq_a_next.rem  = '0;
        sq_a_next.root = '0;
        sq_a_next.rad  = {1'b0, best[MW-2:0], {rmq_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        side_a_reg <= side_a_next;
        sq_a_reg   <= sq_a_next;
    end

    // Square root pipeline, two root bits per stage.
    logic                sq_v_reg    [SQS];
    rmq_pkg::sq_t        sq_reg      [SQS];
    rmq_pkg::side_t      sq_side_reg [SQS];

    for (genvar g = 0; g < SQS; g++)
    begin : g_sq
        rmq_pkg::sq_t   sq_in;
        rmq_pkg::sq_t   sq_next;
        rmq_pkg::side_t side_in;
        logic           v_in;

        if (g == 0)
        begin : g_first
            assign sq_in   = sq_a_reg;
            assign side_in = side_a_reg;
            assign v_in    = a_v_reg;
        end
        else
        begin : g_rest
            assign sq_in   = sq_reg[g-1];
            assign side_in = sq_side_reg[g-1];
            assign v_in    = sq_v_reg[g-1];
        end

        always_comb
        begin
            sq_next = sq_in;
            for (int k = 0; k < rmq_pkg::SQ_PER_STG; k++)
            begin
                if (g * rmq_pkg::SQ_PER_STG + k < rmq_pkg::SQ_ITERS)
                begin
                    sq_next = rmq_pkg::sq_step(sq_next);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[g] <= 1'b0;
            end
            else
            begin
                sq_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[g]      <= sq_next;
            sq_side_reg[g] <= side_in;
        end
    end

    // Dividend setup: (|d| << FRAC_BITS) + s over 2s, plus the dominant term.
    logic [RW-1:0]                s_root;
    logic [RW:0]                  s_inc;
    logic [rmq_pkg::NUM_W-1:0]    numer [3];
    rmq_pkg::dv_t                 dv_p_next [3];
    rmq_pkg::dside_t              dside_p_next;
    logic                         p_v_reg;
    rmq_pkg::dv_t                 dv_p_reg [3];
    rmq_pkg::dside_t              dside_p_reg;

    always_comb
    begin
        s_root = sq_reg[SQS-1].root;
        s_inc  = {1'b0, s_root} + (RW+1)'(1);
        for (int k = 0; k < 3; k++)
        begin
            numer[k] = rmq_pkg::NUM_W'({sq_side_reg[SQS-1].dmag[k],
                                        {rmq_pkg::FRAC_BITS{1'b0}}})
                       + rmq_pkg::NUM_W'(s_root);
            dv_p_next[k].rem = rmq_pkg::DIV_W'(numer[k] >> rmq_pkg::QUO_W);
            dv_p_next[k].quo = '0;
            dv_p_next[k].num = numer[k] << (rmq_pkg::NUM_W - rmq_pkg::QUO_W);
        end
        dside_p_next.idx     = sq_side_reg[SQS-1].idx;
        dside_p_next.neg     = sq_side_reg[SQS-1].neg;
        dside_p_next.dom     = s_inc[RW:1];
        dside_p_next.divisor = {s_root, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= sq_v_reg[SQS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_p_reg    <= dv_p_next;
        dside_p_reg <= dside_p_next;
    end

    // Three parallel divider pipelines, two quotient bits per stage, one in the last.
    logic             dv_v_reg    [DVS];
    rmq_pkg::dv_t     dv_reg      [DVS][3];
    rmq_pkg::dside_t  dv_side_reg [DVS];

    for (genvar g = 0; g < DVS; g++)
    begin : g_dv
        rmq_pkg::dv_t    dv_in   [3];
        rmq_pkg::dv_t    dv_next [3];
        rmq_pkg::dside_t side_in;
        logic            v_in;

        if (g == 0)
        begin : g_first
            assign dv_in   = dv_p_reg;
            assign side_in = dside_p_reg;
            assign v_in    = p_v_reg;
        end
        else
        begin : g_rest
            assign dv_in   = dv_reg[g-1];
            assign side_in = dv_side_reg[g-1];
            assign v_in    = dv_v_reg[g-1];
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                dv_next[c] = dv_in[c];
                for (int k = 0; k < rmq_pkg::DV_PER_STG; k++)
                begin
                    if (g * rmq_pkg::DV_PER_STG + k < rmq_pkg::DV_ITERS)
                    begin
                        dv_next[c] = rmq_pkg::dv_step(dv_next[c], side_in.divisor);
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[g] <= 1'b0;
            end
            else
            begin
                dv_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[g]      <= dv_next;
            dv_side_reg[g] <= side_in;
        end
    end

    // Output stage: place components, fix the sign and saturate.
    localparam int ELEM_SAT = rmq_pkg::ELEM_W;
    logic signed [QW-1:0] qv   [3];
    logic signed [QW-1:0] comp [4];
    logic signed [QW-1:0] fixd [4];
    logic signed [ELEM_SAT-1:0] sat [4];
    rmq_pkg::dside_t      so;
    logic                 done_reg;
    rmq_pkg::quat_t       quat_reg;
    rmq_pkg::quat_t       quat_next;

    always_comb
    begin
        so = dv_side_reg[DVS-1];
        for (int k = 0; k < 3; k++)
        begin
            qv[k] = so.neg[k] ? -QW'(dv_reg[DVS-1][k].quo)
                              :  QW'(dv_reg[DVS-1][k].quo);
        end
        for (int p = 0; p < 4; p++)
        begin
            if (p == int'(so.idx))
            begin
                comp[p] = QW'(so.dom);
            end
            else if (p < int'(so.idx))
            begin
                comp[p] = qv[p];
            end
            else
            begin
                comp[p] = qv[p-1];
            end
        end
        for (int p = 0; p < 4; p++)
        begin
            fixd[p] = comp[0][QW-1] ? -comp[p] : comp[p];
            if (fixd[p] > QW'(32767))
            begin
                sat[p] = 16'sh7fff;
            end
            else if (fixd[p] < -QW'(32768))
            begin
                sat[p] = 16'sh8000;
            end
            else
            begin
                sat[p] = fixd[p][ELEM_SAT-1:0];
            end
        end
        quat_next.out_w = sat[0];
        quat_next.out_x = sat[1];
        quat_next.out_y = sat[2];
        quat_next.out_z = sat[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v_reg[DVS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

    // The scalar part leaves non-negative after the sign fix.
    `RMQ_ASSERT_IMPLY(a_w_nonneg, clk, rst_n, done, !quat.out_w[ELEM_SAT-1])
    // Every accepted beat comes out after the fixed latency.
    `RMQ_ASSERT(a_latency, clk, rst_n, start |-> ##(rmq_pkg::LATENCY) done)
    // The largest candidate is at least 1.0, so the root is at least 1.0.
    `RMQ_ASSERT_IMPLY(a_root_min, clk, rst_n, sq_v_reg[SQS-1],
                      sq_reg[SQS-1].root[RW-1:RW-2] != 2'b00)

endmodule
`default_nettype wire

/* verif/tb_rotation_matrix_to_quaternion.sv */
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion;

    localparam int FB = 14;
    localparam int N_RANDOM = 1000;
    localparam int MAX_CYCLES = 400000;

    // Expected quaternions in order of acceptance, with the mismatch tally.
    class quat_scoreboard;
        rmq_pkg::quat_t pending[$];
        int    n_err;

        function new();
            n_err = 0;
        endfunction

        // Integer square root, bit by bit.
        function longint unsigned root_of(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Off-diagonal term over 2s, rounded half away from zero.
        function longint scaled_quot(longint d, longint unsigned s);
            longint unsigned m;
            longint unsigned q;
            m = (d < 0) ? longint'(-d) : d;
            q = ((m << FB) + s) / (s << 1);
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [15:0] clamp16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        // Work out the quaternion for one accepted matrix beat.
        function void note_matrix(rmq_pkg::matrix_t a);
            longint e00, e01, e02, e10, e11, e12, e20, e21, e22;
            longint one, best;
            longint cand[4];
            longint c[4];
            longint unsigned s;
            rmq_pkg::comp_t dom;
            rmq_pkg::quat_t r;
            e00 = a.a00; e01 = a.a01; e02 = a.a02;
            e10 = a.a10; e11 = a.a11; e12 = a.a12;
            e20 = a.a20; e21 = a.a21; e22 = a.a22;
            one = longint'(1) << FB;
            cand[0] = one + e00 + e11 + e22;
            cand[1] = one + e00 - e11 - e22;
            cand[2] = one - e00 + e11 - e22;
            cand[3] = one - e00 - e11 + e22;
            best = cand[0];
            dom = rmq_pkg::COMP_W;
            for (int i = 1; i < 4; i++)
            begin
                if (cand[i] > best)
                begin
                    best = cand[i];
                    dom = rmq_pkg::comp_t'(i);
                end
            end
            if (best < one)
                best = one;
            s = root_of(longint'(best) << FB);
            if (s == 0)
                s = 1;
            case (dom)
                rmq_pkg::COMP_W:
                begin
                    c[0] = (s + 1) >> 1;
                    c[1] = scaled_quot(e12 - e21, s);
                    c[2] = scaled_quot(e20 - e02, s);
                    c[3] = scaled_quot(e01 - e10, s);
                end
                rmq_pkg::COMP_X:
                begin
                    c[1] = (s + 1) >> 1;
                    c[0] = scaled_quot(e12 - e21, s);
                    c[2] = scaled_quot(e01 + e10, s);
                    c[3] = scaled_quot(e02 + e20, s);
                end
                rmq_pkg::COMP_Y:
                begin
                    c[2] = (s + 1) >> 1;
                    c[0] = scaled_quot(e20 - e02, s);
                    c[1] = scaled_quot(e01 + e10, s);
                    c[3] = scaled_quot(e12 + e21, s);
                end
                default:
                begin
                    c[3] = (s + 1) >> 1;
                    c[0] = scaled_quot(e01 - e10, s);
                    c[1] = scaled_quot(e02 + e20, s);
                    c[2] = scaled_quot(e12 + e21, s);
                end
            endcase
            // Keep the scalar part non-negative.
            if (c[0] < 0)
                for (int i = 0; i < 4; i++)
                    c[i] = -c[i];
            r.out_w = clamp16(c[0]);
            r.out_x = clamp16(c[1]);
            r.out_y = clamp16(c[2]);
            r.out_z = clamp16(c[3]);
            pending.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_quat(rmq_pkg::quat_t got);
            rmq_pkg::quat_t exp_q;
            if (pending.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            exp_q = pending.pop_front();
            if (got.out_w !== exp_q.out_w || got.out_x !== exp_q.out_x ||
                got.out_y !== exp_q.out_y || got.out_z !== exp_q.out_z)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d",
                             exp_q.out_w, exp_q.out_x, exp_q.out_y, exp_q.out_z,
                             " got w=%0d x=%0d y=%0d z=%0d",
                             got.out_w, got.out_x, got.out_y, got.out_z);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    rmq_pkg::matrix_t matrix;
    logic    done;
    rmq_pkg::quat_t   quat;

    quat_scoreboard sb;
    int unsigned    cycles;

    rotation_matrix_to_quaternion u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .matrix(matrix),
        .done  (done),
        .quat  (quat)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result sampling and cycle limit.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_quat(quat);
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("tb_rotation_matrix_to_quaternion failed");
            $finish;
        end
    end

    // Present one matrix beat and hold it until accepted.
    task automatic send_matrix(rmq_pkg::matrix_t m);
        matrix <= m;
        start  <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_matrix(m);
        @(negedge clk);
    endtask

    // Idle gap between beats, mostly short, now and then long.
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0)
            return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'($urandom());
        endcase
    endfunction

    // Random matrix: mostly a signed permutation with small noise, else fully random.
    function automatic rmq_pkg::matrix_t rand_matrix();
        rmq_pkg::matrix_t m;
        logic [15:0] e[9];
        int p[3];
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++)
            e[i] = (mode == 0) ? rand_elem() : 16'($signed($urandom_range(0, 4000)) - 2000);
        if (mode != 0)
        begin
            p[0] = $urandom_range(0, 2);
            p[1] = (p[0] + $urandom_range(1, 2)) % 3;
            p[2] = 3 - p[0] - p[1];
            for (int r = 0; r < 3; r++)
                e[r * 3 + p[r]] = $urandom_range(0, 1) ? 16'sd16000 : -16'sd16000;
        end
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    // Stimulus.
    initial
    begin
        rmq_pkg::matrix_t m;
        sb = new();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        matrix = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: identity, each dominant axis, ties, extremes, sign fix.
        send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384});
        send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, -16'sd16384});
        send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, -16'sd16384});
        send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384});
        send_matrix('0);
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000});
        send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                     16'h7fff, 16'h8000, 16'h7fff});
        // X-dominant diagonal with off-diagonals that drive w negative.
        send_matrix({16'sd16384, 16'h8000, 16'h7fff, 16'h7fff, -16'sd16384, 16'h8000,
                     16'h8000, 16'h7fff, -16'sd16384});
        send_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100,
                     16'sd0, -16'sd100, 16'sd0});
        send_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100,
                     16'sd0, 16'sd100, 16'sd0});
        send_matrix({16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384});

        // Random part; pause once until the pipeline drains.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (sb.pending.size() != 0)
                    @(negedge clk);
            end
            m = rand_matrix();
            send_matrix(m);
            if (i % 200 < 150)
                idle_gap();
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (rmq_pkg::LATENCY + 10) @(negedge clk);

        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("tb_rotation_matrix_to_quaternion passed");
        else
            $display("tb_rotation_matrix_to_quaternion failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rmq_pkg.sv
rtl/core/rotation_matrix_to_quaternion.sv
verif/tb_rotation_matrix_to_quaternion.sv
